[rtl/pngse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngse_pkg
// Shared types, constants and helper functions of the PNG stored-stream
// encoder.
// ----------------------------------------------------------------------------
package pngse_pkg;

    // dimension limits and stored-block size
    localparam logic [12:0] MAX_WIDTH   = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT  = 13'd4096;
    localparam logic [15:0] BLOCK_MAX   = 16'd65535;
    localparam logic [15:0] ADLER_MOD   = 16'd65521;
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

    // request queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // one classified input request
    typedef struct packed {
        logic [7:0] data;
        logic       first;      // first byte of an image: send preamble
        logic       row_start;  // first byte of a row: filter byte first
    } t_entry;

    // clamped image size
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
    } t_dims;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // byte k of a word, most significant first
    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

[rtl/pngse_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngse_front
// Holds the size registers, tracks the position in the image and tags each
// accepted byte as first of image or first of row.
// ----------------------------------------------------------------------------
module pngse_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [12:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_pixel_byte,
    input  logic                 i_q_ready,
    output logic                 o_q_push,
    output pngse_pkg::t_entry    o_q_entry,
    output pngse_pkg::t_dims     o_dims
);
    import pngse_pkg::*;

    logic [12:0] r_width, r_height;
    logic        r_lock;
    logic [14:0] r_col;
    logic [12:0] r_row;
    logic [12:0] w_w, w_h;
    logic [14:0] w_row_bytes;
    logic        w_acc, w_row_end, w_last;

    // clamp sizes: zero acts as one, large values saturate
    always_comb begin
        w_w = (r_width == 13'd0) ? 13'd1 : ((r_width > MAX_WIDTH) ? MAX_WIDTH : r_width);
        w_h = (r_height == 13'd0) ? 13'd1 : ((r_height > MAX_HEIGHT) ? MAX_HEIGHT : r_height);
    end

    assign w_row_bytes = {w_w, 2'b00};
    assign w_acc       = i_valid && i_q_ready;
    assign w_row_end   = (r_col == (w_row_bytes - 15'd1));
    assign w_last      = w_row_end && (r_row == (w_h - 13'd1));

    assign o_ready   = i_q_ready;
    assign o_q_push  = w_acc;
    assign o_q_entry = '{data: i_pixel_byte, first: !r_lock, row_start: (r_col == 15'd0)};
    assign o_dims    = '{width: w_w, height: w_h};

    // size registers, frozen during an image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1;
            r_height <= 13'd1;
        end else if (i_cfg_we && !r_lock) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    // position tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock <= 1'b0;
            r_col  <= 15'd0;
            r_row  <= 13'd0;
        end else if (w_acc) begin
            if (w_last) begin
                r_lock <= 1'b0;
                r_col  <= 15'd0;
                r_row  <= 13'd0;
            end else begin
                r_lock <= 1'b1;
                if (w_row_end) begin
                    r_col <= 15'd0;
                    r_row <= r_row + 13'd1;
                end else begin
                    r_col <= r_col + 15'd1;
                end
            end
        end
    end

endmodule

[rtl/pngse_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngse_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pngse_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pngse_pkg::t_entry    i_entry,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_valid,
    output pngse_pkg::t_entry    o_entry
);
    import pngse_pkg::*;

    localparam logic [Q_AW:0] DEPTH = (Q_AW + 1)'(Q_DEPTH);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_ready = (r_cnt != DEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW + 1)'(i_push) - (Q_AW + 1)'(i_pop);
        end
    end

endmodule

[rtl/pngse_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngse_back
// Byte sequencer: preamble, stored-block headers, raw bytes and trailer,
// with running CRC-32 and Adler-32, one file byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module pngse_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  pngse_pkg::t_entry    i_q_entry,
    output logic                 o_q_pop,
    input  pngse_pkg::t_dims     i_dims,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_run_last,
    output logic                 o_file_end
);
    import pngse_pkg::*;

    localparam logic [1:0] ST_PRE = 2'd0;
    localparam logic [1:0] ST_HDR = 2'd1;
    localparam logic [1:0] ST_RAW = 2'd2;
    localparam logic [1:0] ST_TRL = 2'd3;

    logic        r_busy, n_busy;
    t_entry      r_ent, n_ent;
    logic [1:0]  r_st, n_st;
    logic [5:0]  r_idx, n_idx;
    logic        r_fpend, n_fpend;
    logic [31:0] r_crc, n_crc;
    logic [15:0] r_alo, n_alo, r_ahi, n_ahi;
    logic [15:0] r_blk, n_blk;
    logic [26:0] r_raw, n_raw;
    logic [26:0] r_total, n_total;
    logic [11:0] r_blocks, n_blocks;
    logic [31:0] r_idat, n_idat;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_orl, r_ofe;

    logic        w_adv, w_load;
    logic [7:0]  w_byte;
    logic        w_crc_on, w_crc_rst, w_end, w_fe;
    logic [15:0] w_len;
    logic [16:0] w_s1, w_s2, w_r;
    logic [15:0] w_alo;
    logic [11:0] w_q;

    assign w_adv   = r_busy && (!r_ov || i_ready);
    assign o_valid    = r_ov;
    assign o_out_byte = r_ob;
    assign o_run_last = r_orl;
    assign o_file_end = r_ofe;
    assign o_q_pop    = w_load;

    // stored-block length of the next header
    assign w_len = (r_raw < {11'd0, BLOCK_MAX}) ? r_raw[15:0] : BLOCK_MAX;

    // block count: total split as a*65536+b, so total = a*65535 + (a+b)
    always_comb begin
        w_r = {6'd0, r_total[26:16]} + {1'b0, r_total[15:0]};
        w_q = {1'b0, r_total[26:16]};
        if (w_r >= {1'b0, BLOCK_MAX}) begin
            w_q = w_q + 12'd1;
            w_r = w_r - {1'b0, BLOCK_MAX};
        end
    end

    // Adler-32 step on the raw byte
    always_comb begin
        w_s1  = {1'b0, r_alo} + {9'd0, w_byte};
        if (w_s1 >= {1'b0, ADLER_MOD}) begin
            w_s1 = w_s1 - {1'b0, ADLER_MOD};
        end
        w_alo = w_s1[15:0];
        w_s2  = {1'b0, r_ahi} + {1'b0, w_alo};
        if (w_s2 >= {1'b0, ADLER_MOD}) begin
            w_s2 = w_s2 - {1'b0, ADLER_MOD};
        end
    end

    // sequencer
    always_comb begin
        n_busy   = r_busy;
        n_ent    = r_ent;
        n_st     = r_st;
        n_idx    = r_idx;
        n_fpend  = r_fpend;
        n_crc    = r_crc;
        n_alo    = r_alo;
        n_ahi    = r_ahi;
        n_blk    = r_blk;
        n_raw    = r_raw;
        n_total  = r_total;
        n_blocks = r_blocks;
        n_idat   = r_idat;
        w_byte    = 8'd0;
        w_crc_on  = 1'b0;
        w_crc_rst = 1'b0;
        w_end     = 1'b0;
        w_fe      = 1'b0;

        case (r_st)
            ST_PRE: begin
                case (r_idx)
                    6'd0:  w_byte = 8'd137;
                    6'd1:  w_byte = 8'd80;
                    6'd2:  w_byte = 8'd78;
                    6'd3:  w_byte = 8'd71;
                    6'd4:  w_byte = 8'd13;
                    6'd5:  w_byte = 8'd10;
                    6'd6:  w_byte = 8'd26;
                    6'd7:  w_byte = 8'd10;
                    6'd11: w_byte = 8'd13;
                    6'd12: w_byte = "I";
                    6'd13: w_byte = "H";
                    6'd14: w_byte = "D";
                    6'd15: w_byte = "R";
                    6'd18: w_byte = {3'd0, i_dims.width[12:8]};
                    6'd19: w_byte = i_dims.width[7:0];
                    6'd22: w_byte = {3'd0, i_dims.height[12:8]};
                    6'd23: w_byte = i_dims.height[7:0];
                    6'd24: w_byte = 8'd8;
                    6'd25: w_byte = 8'd6;
                    6'd29, 6'd30, 6'd31, 6'd32:
                        w_byte = word_byte(~r_crc, r_idx[1:0] - 2'd1);
                    6'd33, 6'd34, 6'd35, 6'd36:
                        w_byte = word_byte(r_idat, r_idx[1:0] - 2'd1);
                    6'd37: w_byte = "I";
                    6'd38: w_byte = "D";
                    6'd39: w_byte = "A";
                    6'd40: w_byte = "T";
                    6'd41: w_byte = 8'h78;
                    6'd42: w_byte = 8'h01;
                    default: w_byte = 8'd0;
                endcase
                w_crc_on  = ((r_idx >= 6'd12) && (r_idx <= 6'd28)) || (r_idx >= 6'd37);
                w_crc_rst = (r_idx == 6'd12) || (r_idx == 6'd37);
            end
            ST_HDR: begin
                case (r_idx[2:0])
                    3'd0:    w_byte = {7'd0, (r_raw <= {11'd0, BLOCK_MAX})};
                    3'd1:    w_byte = w_len[7:0];
                    3'd2:    w_byte = w_len[15:8];
                    3'd3:    w_byte = ~w_len[7:0];
                    default: w_byte = ~w_len[15:8];
                endcase
                w_crc_on = 1'b1;
            end
            ST_RAW: begin
                w_byte   = r_fpend ? 8'd0 : r_ent.data;
                w_crc_on = 1'b1;
            end
            default: begin
                case (r_idx[4:2])
                    3'd0:    w_byte = word_byte({r_ahi, r_alo}, r_idx[1:0]);
                    3'd1:    w_byte = word_byte(~r_crc, r_idx[1:0]);
                    3'd2:    w_byte = 8'd0;
                    3'd3: begin
                        case (r_idx[1:0])
                            2'd0:    w_byte = "I";
                            2'd1:    w_byte = "E";
                            2'd2:    w_byte = "N";
                            default: w_byte = "D";
                        endcase
                    end
                    default: w_byte = word_byte(~r_crc, r_idx[1:0]);
                endcase
                w_crc_on  = (r_idx[4:2] == 3'd0) || (r_idx[4:2] == 3'd3);
                w_crc_rst = (r_idx == 6'd12);
            end
        endcase

        if (w_adv) begin
            if (w_crc_on) begin
                n_crc = crc_byte(w_crc_rst ? CRC_INIT : r_crc, w_byte);
            end
            n_idx = r_idx + 6'd1;
            case (r_st)
                ST_PRE: begin
                    // size arithmetic runs during the signature
                    if (r_idx == 6'd0) begin
                        n_total = 27'({i_dims.width, 2'b01}) * 27'(i_dims.height);
                    end
                    if (r_idx == 6'd1) begin
                        n_blocks = w_q + {11'd0, (w_r != 17'd0)};
                    end
                    if (r_idx == 6'd2) begin
                        n_idat = 32'd6 + {18'd0, r_blocks, 2'b00} + {20'd0, r_blocks}
                                 + {5'd0, r_total};
                    end
                    if (r_idx == 6'd42) begin
                        n_st  = ST_HDR;
                        n_idx = 6'd0;
                        n_raw = r_total;
                        n_blk = 16'd0;
                        n_alo = 16'd1;
                        n_ahi = 16'd0;
                    end
                end
                ST_HDR: begin
                    if (r_idx == 6'd4) begin
                        n_blk = w_len;
                        n_st  = ST_RAW;
                        n_idx = 6'd0;
                    end
                end
                ST_RAW: begin
                    n_alo = w_alo;
                    n_ahi = w_s2[15:0];
                    n_blk = r_blk - 16'd1;
                    n_raw = r_raw - 27'd1;
                    n_idx = 6'd0;
                    if (r_fpend) begin
                        n_fpend = 1'b0;
                        if (n_blk == 16'd0) begin
                            n_st = ST_HDR;
                        end
                    end else if (n_raw == 27'd0) begin
                        n_st = ST_TRL;
                    end else begin
                        w_end = 1'b1;
                    end
                end
                default: begin
                    if (r_idx == 6'd19) begin
                        w_end = 1'b1;
                        w_fe  = 1'b1;
                        n_crc = CRC_INIT;
                        n_alo = 16'd1;
                        n_ahi = 16'd0;
                        n_blk = 16'd0;
                        n_raw = 27'd0;
                    end
                end
            endcase
        end

        // take the next request
        w_load = i_q_valid && (!r_busy || w_end);
        if (w_load) begin
            n_busy  = 1'b1;
            n_ent   = i_q_entry;
            n_fpend = i_q_entry.row_start;
            n_idx   = 6'd0;
            n_st    = i_q_entry.first ? ST_PRE : ((n_blk == 16'd0) ? ST_HDR : ST_RAW);
        end else if (w_end) begin
            n_busy = 1'b0;
        end
    end

    // control and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_st    <= ST_PRE;
            r_idx   <= 6'd0;
            r_fpend <= 1'b0;
            r_crc   <= CRC_INIT;
            r_alo   <= 16'd1;
            r_ahi   <= 16'd0;
            r_blk   <= 16'd0;
            r_raw   <= 27'd0;
            r_ov    <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_st    <= n_st;
            r_idx   <= n_idx;
            r_fpend <= n_fpend;
            r_crc   <= n_crc;
            r_alo   <= n_alo;
            r_ahi   <= n_ahi;
            r_blk   <= n_blk;
            r_raw   <= n_raw;
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ent    <= n_ent;
        r_total  <= n_total;
        r_blocks <= n_blocks;
        r_idat   <= n_idat;
        if (w_adv) begin
            r_ob  <= w_byte;
            r_orl <= w_end;
            r_ofe <= w_fe;
        end
    end

    // checks
    a_fe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_ofe |-> r_orl) else $error("file end without request end");
    a_hdr_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_st == ST_HDR) |-> (r_raw != 27'd0)) else $error("header with no data");
    a_adler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alo < ADLER_MOD) && (r_ahi < ADLER_MOD)) else $error("adler out of range");
    a_raw_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_st == ST_RAW) |-> (r_blk != 16'd0)) else $error("raw byte outside block");

endmodule

[rtl/png_stored_stream_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_stream_encoder
// RGBA8 raw image bytes in, complete PNG file (zlib stored blocks) out.
// ----------------------------------------------------------------------------
// The block emits one file byte per clock cycle through a registered output
// while requests are queued and the receiver is ready. An input byte causes one
// file byte as a plain image byte, two at a row start (filter byte), five more
// where a stored block begins, 43 more for the preamble of the first byte and
// 20 more for the trailer of the last. A two-entry request queue lets input be
// taken while the byte sequencer is busy. Width and height writes are ignored
// while an image is in progress. No clearing pass after reset.
module png_stored_stream_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pixel_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_file_end
);
    import pngse_pkg::*;

    logic   w_f_ready, w_push, w_q_valid, w_pop;
    t_entry w_f_entry, w_q_entry;
    t_dims  w_dims;

    pngse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_byte(i_pixel_byte),
        .i_q_ready   (w_f_ready),
        .o_q_push    (w_push),
        .o_q_entry   (w_f_entry),
        .o_dims      (w_dims)
    );

    pngse_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_entry(w_f_entry),
        .o_ready(w_f_ready),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_entry(w_q_entry)
    );

    pngse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_q_entry),
        .o_q_pop   (w_pop),
        .i_dims    (w_dims),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out_byte(o_out_byte),
        .o_run_last(o_run_last),
        .o_file_end(o_file_end)
    );

endmodule
